// ===== design/ndacc_pkg.sv =====
// ----------------------------------------------------------------------------
// ndacc_pkg
// Shared widths for the nucleotide diversity accumulator.
// ----------------------------------------------------------------------------
package ndacc_pkg;

   localparam int STATE_W  = 8;   // allele state code, signed
   localparam int COUNT_W  = 16;  // allele count port width
   localparam int SAMPLE_W = 16;  // sample size port width
   localparam int DENOM_W  = 2 * SAMPLE_W;  // n*(n-1) always fits here

endpackage

// ===== design/ndacc_front.sv =====
// ----------------------------------------------------------------------------
// ndacc_front
// Accepts count words, forms c*(c-1) and accumulates the site pair sum.
// ----------------------------------------------------------------------------
module ndacc_front import ndacc_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic signed [STATE_W-1:0]                req_state_code,
   input  logic        [COUNT_W-1:0]                req_allele_count,
   input  logic        [SAMPLE_W-1:0]               req_sample_size,
   input  logic                                     req_last_in_site,
   input  logic                                     req_last_site,
   output logic                                     q_push,
   output logic        [2*COUNT_BITS+SAMPLE_W:0]    q_data,
   input  logic                                     q_full
);

   localparam int PAIR_BITS = 2 * COUNT_BITS;

   logic [COUNT_BITS-1:0] cnt;
   logic [COUNT_BITS-1:0] cnt_m1;
   logic                  counted;
   logic [PAIR_BITS-1:0]  prod;
   logic                  accept;
   logic                  s1_go;
   logic [PAIR_BITS:0]    pair_add;
   logic [PAIR_BITS-1:0]  pair_sat;

   logic                  s1_valid_ff, s1_valid_in;
   logic [PAIR_BITS-1:0]  s1_prod_ff;
   logic [SAMPLE_W-1:0]   s1_n_ff;
   logic                  s1_close_ff;
   logic                  s1_set_ff;
   logic [PAIR_BITS-1:0]  pair_ff;

   assign cnt     = COUNT_BITS'(req_allele_count);
   assign cnt_m1  = cnt - COUNT_BITS'(1);
   // missing states and counts below two add nothing
   assign counted = !req_state_code[STATE_W-1] && (cnt >= COUNT_BITS'(2));
   assign prod    = counted ? PAIR_BITS'(cnt) * PAIR_BITS'(cnt_m1) : '0;

   // stall only when a site-closing word cannot enter the queue
   assign req_full = s1_valid_ff && s1_close_ff && q_full;
   assign accept   = req_push && !req_full;
   assign s1_go    = s1_valid_ff && !(s1_close_ff && q_full);

   assign pair_add = {1'b0, pair_ff} + {1'b0, s1_prod_ff};
   assign pair_sat = pair_add[PAIR_BITS] ? '1 : pair_add[PAIR_BITS-1:0];

   assign q_push = s1_go && s1_close_ff;
   assign q_data = {pair_sat, s1_n_ff, s1_set_ff};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pair_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            pair_ff <= s1_close_ff ? '0 : pair_sat;
         end
      end
      if (accept) begin
         s1_prod_ff  <= prod;
         s1_n_ff     <= req_sample_size;
         s1_close_ff <= req_last_in_site;
         s1_set_ff   <= req_last_in_site && req_last_site;
      end
   end

endmodule

// ===== design/ndacc_queue.sv =====
// ----------------------------------------------------------------------------
// ndacc_queue
// Two-entry queue carrying closed sites from front to back.
// ----------------------------------------------------------------------------
module ndacc_queue import ndacc_pkg::*; #(
   parameter int WIDTH = 49
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/ndacc_back.sv =====
// ----------------------------------------------------------------------------
// ndacc_back
// Per-site divide, heterozygosity, saturating running sum, result register.
// ----------------------------------------------------------------------------
module ndacc_back import ndacc_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 20,
   parameter int SITE_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  logic [2*COUNT_BITS+SAMPLE_W:0]    q_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [FRAC_BITS:0]                rsp_site_heterozygosity,
   output logic [SITE_BITS+FRAC_BITS-1:0]    rsp_diversity_sum,
   output logic                              rsp_bad_sample_size,
   output logic                              rsp_set_done
);

   localparam int PAIR_BITS = 2 * COUNT_BITS;
   localparam int HET_BITS  = FRAC_BITS + 1;
   localparam int SUM_BITS  = SITE_BITS + FRAC_BITS;
   localparam int CMP_W     = (PAIR_BITS > DENOM_W) ? PAIR_BITS : DENOM_W;
   localparam int STEP_W    = $clog2(FRAC_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DENOM,
      ST_DIVIDE,
      ST_FINISH
   } back_state_type;

   back_state_type        state_ff;
   logic [PAIR_BITS-1:0]  sum_ff;
   logic [SAMPLE_W-1:0]   n_ff;
   logic                  set_ff;
   logic                  bad_ff;
   logic                  zero_ff;
   logic [DENOM_W-1:0]    denom_ff;
   logic [DENOM_W-1:0]    rem_ff;
   logic [FRAC_BITS-1:0]  quo_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [SUM_BITS-1:0]   acc_ff;
   logic                  out_valid_ff;
   logic [HET_BITS-1:0]   out_het_ff;
   logic [SUM_BITS-1:0]   out_sum_ff;
   logic                  out_bad_ff;
   logic                  out_set_ff;

   logic [DENOM_W-1:0]    denom_calc;
   logic                  sum_ge_denom;
   logic [DENOM_W:0]      trial;
   logic                  trial_fits;
   logic [HET_BITS-1:0]   het;
   logic [SUM_BITS:0]     acc_add;
   logic [SUM_BITS-1:0]   acc_new;
   logic                  out_free;
   logic                  in_bad;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign in_bad    = q_data[SAMPLE_W:1] < SAMPLE_W'(2);
   assign out_free  = !out_valid_ff || rsp_pop;

   assign denom_calc   = DENOM_W'(n_ff) * DENOM_W'(n_ff - SAMPLE_W'(1));
   assign sum_ge_denom = CMP_W'(sum_ff) >= CMP_W'(denom_ff);

   // restoring divide, one quotient bit per cycle
   assign trial      = {rem_ff, 1'b0};
   assign trial_fits = trial >= {1'b0, denom_ff};

   assign het     = zero_ff ? '0 : ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, quo_ff});
   assign acc_add = {1'b0, acc_ff} + (SUM_BITS + 1)'(het);
   assign acc_new = bad_ff ? acc_ff :
                    (acc_add[SUM_BITS] ? '1 : acc_add[SUM_BITS-1:0]);

   assign rsp_empty               = !out_valid_ff;
   assign rsp_site_heterozygosity = out_het_ff;
   assign rsp_diversity_sum       = out_sum_ff;
   assign rsp_bad_sample_size     = out_bad_ff;
   assign rsp_set_done            = out_set_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // in ST_FINISH a pop frees the register for the next word below
         if (rsp_pop && out_valid_ff && (state_ff != ST_FINISH)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  state_ff <= ST_DENOM;
               end
            end
            ST_DENOM: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (zero_ff || step_ff == STEP_W'(FRAC_BITS - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  acc_ff       <= set_ff ? '0 : acc_new;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            sum_ff <= q_data[PAIR_BITS+SAMPLE_W:SAMPLE_W+1];
            n_ff   <= q_data[SAMPLE_W:1];
            set_ff <= q_data[0];
            bad_ff <= in_bad;
         end
         ST_DENOM: begin
            denom_ff <= denom_calc;
            step_ff  <= '0;
            quo_ff   <= '0;
         end
         ST_DIVIDE: begin
            // first cycle settles the clamp; sum < denom below keeps rem narrow
            if (step_ff == '0 && !zero_ff && sum_ge_denom) begin
               zero_ff <= 1'b1;
            end else begin
               if (trial_fits) begin
                  rem_ff <= DENOM_W'(trial - {1'b0, denom_ff});
               end else begin
                  rem_ff <= trial[DENOM_W-1:0];
               end
               quo_ff  <= {quo_ff[FRAC_BITS-2:0], trial_fits};
               step_ff <= step_ff + STEP_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_het_ff <= het;
               out_sum_ff <= acc_new;
               out_bad_ff <= bad_ff;
               out_set_ff <= set_ff;
            end
         end
         default: begin
         end
      endcase

      // seed the divider while the denominator is formed
      if (state_ff == ST_DENOM) begin
         rem_ff  <= DENOM_W'(sum_ff);
         zero_ff <= bad_ff;
      end
   end

endmodule

// ===== design/nucleotide_diversity_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// nucleotide_diversity_accumulator_core
// Theta-pi accumulator: per-site heterozygosity and saturating running sum.
// ----------------------------------------------------------------------------
// Count words enter one per cycle while req_full is low. Each word carries one
// allele state and its count c at the current site; words with a negative
// state code are skipped. The front sums c*(c-1) into the site pair sum (one
// registered multiply, then a saturating add). A word marked last_in_site
// closes the site and drops the pair sum, n and the set mark into a two-entry
// queue. The back forms n*(n-1), then runs a restoring divider one quotient
// bit per cycle. Each site passes the back's idle, denominator, divide and
// finish states; the finish state loads the result register, and the divider
// sets the sustained site rate. Words inside a site are taken every cycle;
// req_full rises only when a closing word meets a full queue. The result
// register lets the next site divide while a result waits for pop.
// Heterozygosity is 1 - sum/(n*(n-1)), truncated to FRAC_BITS fraction bits,
// clamped to zero when the counts exceed n*(n-1). Sample size below two flags
// bad_sample_size, reports zero and leaves the running sum alone. The running
// sum saturates and clears after the word that carries set_done.
// ----------------------------------------------------------------------------
module nucleotide_diversity_accumulator_core import ndacc_pkg::*; #(
   parameter int COUNT_BITS = 16,
   parameter int FRAC_BITS  = 20,
   parameter int SITE_BITS  = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [STATE_W-1:0]         req_state_code,
   input  logic        [COUNT_W-1:0]         req_allele_count,
   input  logic        [SAMPLE_W-1:0]        req_sample_size,
   input  logic                              req_last_in_site,
   input  logic                              req_last_site,
   // result words
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [FRAC_BITS:0]                rsp_site_heterozygosity,
   output logic [SITE_BITS+FRAC_BITS-1:0]    rsp_diversity_sum,
   output logic                              rsp_bad_sample_size,
   output logic                              rsp_set_done
);

   localparam int ENTRY_W = 2 * COUNT_BITS + SAMPLE_W + 1;

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   logic [ENTRY_W-1:0] q_wdata;
   logic [ENTRY_W-1:0] q_rdata;

   // front: accept, multiply, accumulate pair sum
   ndacc_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_state_code   (req_state_code),
      .req_allele_count (req_allele_count),
      .req_sample_size  (req_sample_size),
      .req_last_in_site (req_last_in_site),
      .req_last_site    (req_last_site),
      .q_push           (q_push),
      .q_data           (q_wdata),
      .q_full           (q_full)
   );

   // closed sites: {pair sum, n, set mark}
   ndacc_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   // back: divide, heterozygosity, running sum, result register
   ndacc_back #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .SITE_BITS  (SITE_BITS)
   ) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_empty                 (q_empty),
      .q_pop                   (q_pop),
      .q_data                  (q_rdata),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_site_heterozygosity (rsp_site_heterozygosity),
      .rsp_diversity_sum       (rsp_diversity_sum),
      .rsp_bad_sample_size     (rsp_bad_sample_size),
      .rsp_set_done            (rsp_set_done)
   );

   // input backpressure only comes from a full site queue
   a_full_needs_queue: assert property (@(posedge clock) disable iff (reset)
      req_full |-> q_full)
      else $error("req_full without a full site queue");

   // a flagged site reports zero heterozygosity
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_bad_sample_size) |-> (rsp_site_heterozygosity == '0))
      else $error("bad sample size with nonzero heterozygosity");

   // heterozygosity never exceeds one
   a_het_le_one: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_site_heterozygosity <= {1'b1, {FRAC_BITS{1'b0}}}))
      else $error("heterozygosity above one");

endmodule
